// File: hdl/assert_macros.svh
// Assertion helpers for the assertion checker urc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/urc_pkg.sv
package urc_pkg;

  localparam int TIME_BITS   = 32;
  localparam int CD_W        = 24;
  localparam int TRIG_W      = 8;
  localparam int PHASE_W     = TRIG_W + 1;
  localparam int DIST_W      = 30;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // A tick of echo adds 170/1000 mm, kept as millimeters plus a remainder in hundredths.
  localparam int DIST_NUM    = 17;
  localparam int DIST_DEN    = 100;
  localparam int REM_W       = 7;

  localparam logic [CD_W-1:0]   CD_FALL_RESET = CD_W'(250000);
  localparam logic [CD_W-1:0]   CD_RISE_RESET = CD_W'(250000);
  localparam logic [TRIG_W-1:0] LEAD_RESET    = TRIG_W'(4);
  localparam logic [TRIG_W-1:0] WIDTH_RESET   = TRIG_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_FALL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_RISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEAD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 2'd3;

  typedef struct packed {
    logic trig;
    logic fresh;
    logic busy;
  } flags_t;

  typedef struct packed {
    flags_t             flags;
    logic [DIST_W-1:0]  quo;
  } div_beat_t;

endpackage

// File: hdl/ultrasonic_ranging_controller_core.sv
// Trigger and echo range finder controller. Every input beat is one microsecond tick carrying
// the sampled echo level, and every input beat yields exactly one output beat with the trigger
// level for that tick, the last completed distance in millimeters, a flag on the tick a
// distance completes, and the busy status. The block takes one beat per clock cycle while
// in_stall is low; a beat updates the tick state and its result is registered in the same
// cycle, then moves through the output register to the outputs. The distance is built up
// tick by tick between the two echo edges, so no division is needed at completion. The
// configuration port is always ready and should be written only while no beat is in flight.
// There is no echo timeout: without two echo edges the block stays busy.
module ultrasonic_ranging_controller_core
  import urc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  echo_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  trigger_level,
  output logic [DIST_W-1:0]     range_mm,
  output logic                  distance_new,
  output logic                  busy_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      ctrl_valid;
  logic      ctrl_ready;
  div_beat_t ctrl_beat;

  urc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .echo_level (echo_level),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .o_valid    (ctrl_valid),
    .o_ready    (ctrl_ready),
    .o_beat     (ctrl_beat)
  );

  urc_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (ctrl_valid),
    .in_ready      (ctrl_ready),
    .in_beat       (ctrl_beat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .range_mm      (range_mm),
    .distance_new  (distance_new),
    .busy_res      (busy_res)
  );

endmodule

// File: hdl/urc_ctrl.sv
module urc_ctrl
  import urc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  echo_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  o_valid,
  input  logic                  o_ready,
  output div_beat_t             o_beat
);

  logic [CD_W-1:0]      cd_fall;
  logic [CD_W-1:0]      cd_rise;
  logic [TRIG_W-1:0]    lead;
  logic [TRIG_W-1:0]    width;

  logic [TIME_BITS-1:0] tick_count;
  logic [TIME_BITS-1:0] rise_stamp;
  logic [TIME_BITS-1:0] fall_stamp;
  logic [DIST_W-1:0]    acc_quo;
  logic [REM_W-1:0]     acc_rem;
  logic                 rise_seen;
  logic                 fall_seen;
  logic                 in_meas;
  logic [PHASE_W-1:0]   phase;
  logic                 echo_prev;

  logic [TIME_BITS-1:0] rise_stamp_next;
  logic [TIME_BITS-1:0] fall_stamp_next;
  logic [DIST_W-1:0]    acc_quo_next;
  logic [REM_W-1:0]     acc_rem_next;
  logic                 rise_seen_next;
  logic                 fall_seen_next;
  logic                 in_meas_next;
  logic [PHASE_W-1:0]   phase_next;
  div_beat_t            beat_next;

  logic                 in_accept;
  logic                 cool_fall;
  logic                 cool_rise;
  logic                 span_wrap;
  logic [PHASE_W-1:0]   seq_end;
  logic [DIST_W-1:0]    step_quo;
  logic [REM_W-1:0]     step_rem;

  assign cfg_ready = 1'b1;
  assign in_stall  = o_valid && !o_ready;
  assign in_accept = in_valid && !in_stall;

  assign cool_fall = !fall_seen ||
                     ((tick_count - fall_stamp) >= TIME_BITS'(cd_fall));
  assign cool_rise = !rise_seen ||
                     ((tick_count - rise_stamp) >= TIME_BITS'(cd_rise));
  assign seq_end   = PHASE_W'(lead) + PHASE_W'(width);
  assign span_wrap = tick_count == rise_stamp;

  urc_div_stage u_step (
    .quo      (acc_quo),
    .rem      (acc_rem),
    .quo_next (step_quo),
    .rem_next (step_rem)
  );

  always_comb begin
    rise_stamp_next = rise_stamp;
    fall_stamp_next = fall_stamp;
    acc_quo_next    = acc_quo;
    acc_rem_next    = acc_rem;
    rise_seen_next  = rise_seen;
    fall_seen_next  = fall_seen;
    in_meas_next    = in_meas;
    phase_next      = phase;
    beat_next       = '0;

    if (phase == '0) begin
      if (in_meas) begin
        if (rise_seen && fall_seen) begin
          beat_next.quo         = acc_quo;
          beat_next.flags.fresh = 1'b1;
          in_meas_next          = 1'b0;
        end
      end else if (cool_fall && cool_rise) begin
        in_meas_next   = 1'b1;
        rise_seen_next = 1'b0;
        fall_seen_next = 1'b0;
        phase_next     = PHASE_W'(1);
      end
    end

    if (phase_next != '0) begin
      beat_next.flags.trig = (phase_next > PHASE_W'(lead)) && (phase_next <= seq_end);
      phase_next = phase_next + PHASE_W'(1);
      if (phase_next > seq_end) begin
        phase_next = '0;
      end
    end

    // The distance grows on every tick after the rise up to and including the fall.
    // A span that wraps the tick counter starts again from zero.
    if (rise_seen_next && !fall_seen_next) begin
      if (span_wrap) begin
        acc_quo_next = '0;
        acc_rem_next = '0;
      end else begin
        acc_quo_next = step_quo;
        acc_rem_next = step_rem;
      end
    end

    if (echo_level != echo_prev) begin
      if (!rise_seen_next) begin
        rise_seen_next  = 1'b1;
        rise_stamp_next = tick_count;
        acc_quo_next    = '0;
        acc_rem_next    = '0;
      end else if (!fall_seen_next) begin
        fall_seen_next  = 1'b1;
        fall_stamp_next = tick_count;
      end
    end

    beat_next.flags.busy = in_meas_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_fall    <= CD_FALL_RESET;
      cd_rise    <= CD_RISE_RESET;
      lead       <= LEAD_RESET;
      width      <= WIDTH_RESET;
      tick_count <= '0;
      rise_seen  <= 1'b0;
      fall_seen  <= 1'b0;
      in_meas    <= 1'b0;
      phase      <= '0;
      echo_prev  <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_COOLDOWN_FALL: cd_fall <= cfg_data;
          CFG_COOLDOWN_RISE: cd_rise <= cfg_data;
          CFG_TRIGGER_LEAD:  lead    <= cfg_data[TRIG_W-1:0];
          CFG_TRIGGER_WIDTH: width   <= cfg_data[TRIG_W-1:0];
        endcase
      end
      if (in_accept) begin
        tick_count <= tick_count + TIME_BITS'(1);
        rise_seen  <= rise_seen_next;
        fall_seen  <= fall_seen_next;
        in_meas    <= in_meas_next;
        phase      <= phase_next;
        echo_prev  <= echo_level;
      end
      if (!o_valid || o_ready) begin
        o_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rise_stamp <= rise_stamp_next;
      fall_stamp <= fall_stamp_next;
      acc_quo    <= acc_quo_next;
      acc_rem    <= acc_rem_next;
      o_beat     <= beat_next;
    end
  end

endmodule

// File: hdl/urc_div_stage.sv
module urc_div_stage
  import urc_pkg::*;
(
  input  logic [DIST_W-1:0] quo,
  input  logic [REM_W-1:0]  rem,
  output logic [DIST_W-1:0] quo_next,
  output logic [REM_W-1:0]  rem_next
);

  logic [REM_W-1:0] sum;
  logic             carry;

  // One tick of echo: the remainder gains its step and carries into the millimeters.
  assign sum      = rem + REM_W'(DIST_NUM);
  assign carry    = sum >= REM_W'(DIST_DEN);
  assign rem_next = carry ? (sum - REM_W'(DIST_DEN)) : sum;
  assign quo_next = quo + DIST_W'(carry);

endmodule

// File: hdl/urc_out.sv
module urc_out
  import urc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  div_beat_t         in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              trigger_level,
  output logic [DIST_W-1:0] range_mm,
  output logic              distance_new,
  output logic              busy_res
);

  logic [DIST_W-1:0] last_dist;
  logic [DIST_W-1:0] dist_next;
  logic              load;

  assign in_ready  = !out_valid || !out_stall;
  assign load      = in_ready && in_valid;
  assign dist_next = in_beat.flags.fresh ? in_beat.quo : last_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_dist <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        last_dist <= dist_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trigger_level <= in_beat.flags.trig;
      range_mm      <= dist_next;
      distance_new  <= in_beat.flags.fresh;
      busy_res      <= in_beat.flags.busy;
    end
  end

endmodule

// File: hdl/urc_checker.sv
`include "assert_macros.svh"

module urc_checker
  import urc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  trigger_level,
  input logic [DIST_W-1:0]     range_mm,
  input logic                  distance_new,
  input logic                  busy_res
);

  logic [DIST_W-1:0] seen_dist;
  logic              out_beat;

  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_dist <= '0;
    end else if (out_beat && distance_new) begin
      seen_dist <= range_mm;
    end
  end

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(range_mm))
  `ASSERT_IMPLY(a_dist_kept, out_valid && !distance_new, range_mm == seen_dist)
  `ASSERT_IMPLY(a_done_not_busy, out_valid && distance_new, !busy_res)
  `ASSERT_IMPLY(a_trig_busy, out_valid && trigger_level, busy_res)

endmodule

bind ultrasonic_ranging_controller_core urc_checker u_urc_checker (.*);

// File: tb/ultrasonic_ranging_checker.sv
module ultrasonic_ranging_checker
  import urc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  echo_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  trigger_level,
  input  logic [DIST_W-1:0]     range_mm,
  input  logic                  distance_new,
  input  logic                  busy_res,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    beats_pending
);

  typedef struct packed {
    logic              trig;
    logic [DIST_W-1:0] range_mm;
    logic              fresh;
    logic              busy;
  } range_beat_t;

  range_beat_t range_beats_q[$];

  logic [CD_W-1:0]      cd_fall;
  logic [CD_W-1:0]      cd_rise;
  logic [TRIG_W-1:0]    lead_ticks;
  logic [TRIG_W-1:0]    width_ticks;

  logic [TIME_BITS-1:0] tick_count;
  logic [TIME_BITS-1:0] rise_time;
  logic [TIME_BITS-1:0] fall_time;
  logic                 rise_seen;
  logic                 fall_seen;
  logic                 measuring;
  int                   seq_phase;
  logic                 echo_last;
  logic [DIST_W-1:0]    dist_last;

  function automatic bit cooled(logic seen, logic [TIME_BITS-1:0] stamp,
                                logic [TIME_BITS-1:0] now, logic [CD_W-1:0] hold_ticks);
    logic [TIME_BITS-1:0] elapsed;
    elapsed = now - stamp;
    return !seen || (elapsed >= TIME_BITS'(hold_ticks));
  endfunction

  task automatic advance_tick(input logic echo, output range_beat_t beat);
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] span;
    int                   seq_end;
    now = tick_count;
    beat = '0;
    if (seq_phase == 0) begin
      if (measuring) begin
        if (rise_seen && fall_seen) begin
          span = fall_time - rise_time;
          dist_last = DIST_W'((64'(span) * 64'd170) / 64'd1000);
          measuring = 1'b0;
          beat.fresh = 1'b1;
        end
      end else if (cooled(fall_seen, fall_time, now, cd_fall) &&
                   cooled(rise_seen, rise_time, now, cd_rise)) begin
        measuring = 1'b1;
        rise_seen = 1'b0;
        fall_seen = 1'b0;
        rise_time = '0;
        fall_time = '0;
        seq_phase = 1;
      end
    end
    if (seq_phase != 0) begin
      seq_end = int'(lead_ticks) + int'(width_ticks);
      if (seq_phase > int'(lead_ticks) && seq_phase <= seq_end) beat.trig = 1'b1;
      seq_phase++;
      if (seq_phase > seq_end) seq_phase = 0;
    end
    if (echo != echo_last) begin
      if (!rise_seen) begin
        rise_seen = 1'b1;
        rise_time = now;
      end else if (!fall_seen) begin
        fall_seen = 1'b1;
        fall_time = now;
      end
    end
    echo_last = echo;
    tick_count = tick_count + TIME_BITS'(1);
    beat.range_mm = dist_last;
    beat.busy = measuring;
  endtask

  task automatic check_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    range_beat_t predicted;
    range_beat_t oldest;
    if (rst) begin
      cd_fall     = CD_FALL_RESET;
      cd_rise     = CD_RISE_RESET;
      lead_ticks  = LEAD_RESET;
      width_ticks = WIDTH_RESET;
      tick_count  = '0;
      rise_time   = '0;
      fall_time   = '0;
      rise_seen   = 1'b0;
      fall_seen   = 1'b0;
      measuring   = 1'b0;
      seq_phase   = 0;
      echo_last   = 1'b0;
      dist_last   = '0;
      range_beats_q.delete();
      error_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COOLDOWN_FALL: cd_fall = cfg_data[CD_W-1:0];
          CFG_COOLDOWN_RISE: cd_rise = cfg_data[CD_W-1:0];
          CFG_TRIGGER_LEAD:  lead_ticks = cfg_data[TRIG_W-1:0];
          CFG_TRIGGER_WIDTH: width_ticks = cfg_data[TRIG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_tick(echo_level, predicted);
        range_beats_q.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (range_beats_q.size() == 0) begin
          $display("%0t: result beat with no expected value, actual distance %0d",
                   $time, range_mm);
          error_count++;
        end else begin
          oldest = range_beats_q.pop_front();
          check_field("trigger_level", DIST_W'(oldest.trig), DIST_W'(trigger_level));
          check_field("range_mm", oldest.range_mm, range_mm);
          check_field("distance_new", DIST_W'(oldest.fresh), DIST_W'(distance_new));
          check_field("busy_res", DIST_W'(oldest.busy), DIST_W'(busy_res));
        end
      end
    end
    beats_pending = range_beats_q.size();
  end

endmodule

// File: tb/tb_ultrasonic_ranging_controller_core.sv
module tb_ultrasonic_ranging_controller_core;
  import urc_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [CD_W-1:0] CD_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  echo_level = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  trigger_level;
  logic [DIST_W-1:0]     range_mm;
  logic                  distance_new;
  logic                  busy_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    error_count;
  int                    beats_pending;

  int                    idle_cycles = 0;
  int                    burst_left = 0;
  int                    echo_run = 0;
  logic                  echo_now = 1'b0;
  int                    stall_mode = 0;
  int                    mode_left = 0;
  int                    stall_left = 0;
  logic                  stall_hold = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ultrasonic_ranging_controller_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .range_mm      (range_mm),
    .distance_new  (distance_new),
    .busy_res      (busy_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ultrasonic_ranging_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .range_mm      (range_mm),
    .distance_new  (distance_new),
    .busy_res      (busy_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .beats_pending (beats_pending)
  );

  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left  <= $urandom_range(20, 200);
      stall_mode <= $urandom_range(0, 3);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left == 0) begin
          stall_hold <= !stall_hold;
          stall_left <= $urandom_range(1, 30);
        end else begin
          stall_left <= stall_left - 1;
        end
        out_stall <= stall_hold;
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ultrasonic_ranging_controller_core failed");
      $finish;
    end
  end

  task automatic send_beat(input logic echo);
    in_valid   <= 1'b1;
    echo_level <= echo;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CD_W-1:0] fall, input logic [CD_W-1:0] rise,
                                input logic [TRIG_W-1:0] lead, input logic [TRIG_W-1:0] width);
    logic [CFG_DATA_W-1:0] d;
    in_valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(CFG_COOLDOWN_FALL, fall);
    write_reg(CFG_COOLDOWN_RISE, rise);
    d = CFG_DATA_W'($urandom);
    d[TRIG_W-1:0] = lead;
    write_reg(CFG_TRIGGER_LEAD, d);
    d = CFG_DATA_W'($urandom);
    d[TRIG_W-1:0] = width;
    write_reg(CFG_TRIGGER_WIDTH, d);
    cfg_valid <= 1'b0;
  endtask

  // Echo is mostly clean pulses of random length, with short glitches mixed in.
  task automatic next_echo();
    if (echo_run == 0) begin
      echo_now = !echo_now;
      echo_run = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 40);
    end else begin
      echo_run--;
    end
  endtask

  task automatic run_random(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end else if ($urandom_range(0, 199) == 0) begin
        in_valid <= 1'b0;
        wait (beats_pending == 0);
        @(negedge clk);
      end
      next_echo();
      send_beat(echo_now);
      burst_left--;
    end
  endtask

  initial begin
    int                count;
    logic [CD_W-1:0]   fall;
    logic [CD_W-1:0]   rise;
    logic [TRIG_W-1:0] lead;
    logic [TRIG_W-1:0] width;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Both echo edges land inside the trigger sequence, and a late edge must be ignored.
    for (int i = 0; i < 20; i++) begin
      send_beat((i >= 2 && i < 6) || i >= 17);
    end
    echo_now = 1'b1;

    apply_settings('0, '0, '0, '0);
    for (int i = 0; i < 5; i++) begin
      echo_now = !echo_now;
      send_beat(echo_now);
    end

    for (int p = 0; p < 10; p++) begin
      lead  = TRIG_W'($urandom_range(0, 20));
      width = TRIG_W'($urandom_range(0, 20));
      fall  = CD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                 : $urandom_range(0, 60));
      rise  = CD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                 : $urandom_range(0, 60));
      count = 150;
      case (p)
        0: begin
          fall  = '0;
          rise  = '0;
          lead  = '0;
          width = 8'd1;
        end
        1: begin
          fall  = '0;
          rise  = '0;
          lead  = '1;
          width = '1;
          count = 560;
        end
        2: begin
          fall  = CD_MAX;
          rise  = CD_MAX;
          count = 60;
        end
        default: ;
      endcase
      apply_settings(fall, rise, lead, width);
      run_random(count);
    end

    in_valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && beats_pending == 0) begin
      $display("tb_ultrasonic_ranging_controller_core passed");
    end else begin
      $display("tb_ultrasonic_ranging_controller_core failed");
    end
    $finish;
  end

endmodule
